// ----- src/hierarchical_timer_wheel_defines.svh -----
// Assertion macros shared by the timer wheel checker
`ifndef HIERARCHICAL_TIMER_WHEEL_DEFINES_SVH
`define HIERARCHICAL_TIMER_WHEEL_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define HTW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hierarchical_timer_wheel: check failed");

// next-cycle implication, sampled on clk, off during reset
`define HTW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hierarchical_timer_wheel: check failed");

`endif

// ----- src/htw_pkg.sv -----
// Types and constants of the hierarchical timer wheel
package htw_pkg;

    localparam int ID_W       = 5;
    localparam int TIME_W     = 64;
    localparam int OP_W       = 2;
    localparam int NUM_LEVELS = 4;
    localparam int LVL_W      = 2;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 64;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    localparam logic [0:0] REG_START_TIME = 1'b0;

    localparam logic [TIME_W-1:0] TOP_CLAMP = 64'h0000_0000_ffff_ffff;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ID_W-1:0]   timer_id;
        logic [TIME_W-1:0] expiry;
    } op_beat_t;

    typedef struct packed {
        logic [ID_W-1:0]   fired_timer;
        logic [TIME_W-1:0] fire_time;
        logic              last;
    } fire_beat_t;

    typedef struct packed {
        logic accept;
        logic start_tick;
        logic walk_first;
        logic walk_next;
        logic level_next;
        logic place_from_ram;
        logic place_calc;
        logic place_write;
        logic fire;
        logic flush;
        logic advance;
    } htw_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] in_op;
        logic            in_id_ok;
        logic            root_zero;
        logic            level_zero;
        logic            last_level;
        logic            walk_last;
        logic            entry_valid;
        logic            cascade_hit;
        logic            fire_hit;
        logic            held_valid;
        logic            out_free;
    } htw_status_t;

endpackage

// ----- src/hierarchical_timer_wheel.sv -----
// Top level of the hierarchical timer wheel
//
//   channel   signals                          direction  beat
//   op        op_valid / op_stall / op_beat    in         add, remove or tick
//   fire      fire_valid / fire_stall / fire_beat out     one expired timer
//   config    APB psel/penable/pwrite/paddr    in         start_time at 0x0
//
// Remove completes at accept, add goes through a calc and a write state; a tick is
// accepted, then runs up to four cascade passes when the root index wraps, one fire
// pass and a flush. A pass walks MAX_TIMERS entries, waiting on live ones, rewriting cascaded ones.
// Reset clears time, valid bits and the sequencer; entry RAM needs no clearing.
// A stalled fire beat holds the walk until the result register frees.
module hierarchical_timer_wheel
    import htw_pkg::*;
#(
    parameter int MAX_TIMERS = 32,
    parameter int ROOT_BITS  = 8,
    parameter int LEVEL_BITS = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_valid,
    output logic               op_stall,
    input  op_beat_t           op_beat,
    output logic               fire_valid,
    input  logic               fire_stall,
    output fire_beat_t         fire_beat,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    htw_cmd_t    cmd;
    htw_status_t status;

    htw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op_stall (op_stall),
        .status   (status),
        .cmd      (cmd)
    );

    htw_dp #(
        .MAX_TIMERS (MAX_TIMERS),
        .ROOT_BITS  (ROOT_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_beat    (op_beat),
        .fire_beat  (fire_beat),
        .fire_valid (fire_valid),
        .fire_stall (fire_stall),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

// ----- src/htw_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module htw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/htw_ctrl.sv -----
// Sequencer of the timer wheel: add, remove, cascade and fire passes
module htw_ctrl
    import htw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        op_valid,
    output logic        op_stall,
    input  htw_status_t status,
    output htw_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_ADD_CALC  = 4'd1;
    localparam logic [3:0] S_ADD_WRITE = 4'd2;
    localparam logic [3:0] S_CAS_READ  = 4'd3;
    localparam logic [3:0] S_CAS_WAIT  = 4'd4;
    localparam logic [3:0] S_CAS_WRITE = 4'd5;
    localparam logic [3:0] S_FIRE_READ = 4'd6;
    localparam logic [3:0] S_FIRE_WAIT = 4'd7;
    localparam logic [3:0] S_FLUSH     = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       cas_step;
    logic       fire_step;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cas_step   = 1'b0;
        fire_step  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                begin
                    cmd.accept = 1'b1;
                    case (status.in_op)
                        OP_ADD:
                        begin
                            if (status.in_id_ok)
                            begin
                                state_next = S_ADD_CALC;
                            end
                        end
                        OP_TICK:
                        begin
                            cmd.start_tick = 1'b1;
                            if (status.root_zero)
                            begin
                                state_next = S_CAS_READ;
                            end
                            else
                            begin
                                cmd.advance = 1'b1;
                                state_next  = S_FIRE_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD_CALC:
            begin
                cmd.place_calc = 1'b1;
                state_next     = S_ADD_WRITE;
            end
            S_ADD_WRITE:
            begin
                cmd.place_write = 1'b1;
                state_next      = S_IDLE;
            end
            S_CAS_READ:
            begin
                if (status.entry_valid)
                begin
                    state_next = S_CAS_WAIT;
                end
                else
                begin
                    cas_step = 1'b1;
                end
            end
            S_CAS_WAIT:
            begin
                if (status.cascade_hit)
                begin
                    cmd.place_calc     = 1'b1;
                    cmd.place_from_ram = 1'b1;
                    state_next         = S_CAS_WRITE;
                end
                else
                begin
                    cas_step = 1'b1;
                end
            end
            S_CAS_WRITE:
            begin
                cmd.place_write = 1'b1;
                cas_step        = 1'b1;
            end
            S_FIRE_READ:
            begin
                if (status.entry_valid)
                begin
                    state_next = S_FIRE_WAIT;
                end
                else
                begin
                    fire_step = 1'b1;
                end
            end
            S_FIRE_WAIT:
            begin
                if (!status.fire_hit)
                begin
                    fire_step = 1'b1;
                end
                else if (!status.held_valid || status.out_free)
                begin
                    cmd.fire  = 1'b1;
                    fire_step = 1'b1;
                end
            end
            S_FLUSH:
            begin
                if (!status.held_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cas_step)
        begin
            if (!status.walk_last)
            begin
                cmd.walk_next = 1'b1;
                state_next    = S_CAS_READ;
            end
            else if (status.level_zero && !status.last_level)
            begin
                cmd.level_next = 1'b1;
                cmd.walk_first = 1'b1;
                state_next     = S_CAS_READ;
            end
            else
            begin
                cmd.advance    = 1'b1;
                cmd.walk_first = 1'b1;
                state_next     = S_FIRE_READ;
            end
        end

        if (fire_step)
        begin
            if (!status.walk_last)
            begin
                cmd.walk_next = 1'b1;
                state_next    = S_FIRE_READ;
            end
            else
            begin
                state_next = S_FLUSH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign op_stall = (state_reg != S_IDLE);

endmodule

// ----- src/htw_dp.sv -----
// Datapath of the timer wheel: time, entry table, placement and result register
module htw_dp
    import htw_pkg::*;
#(
    parameter int MAX_TIMERS = 32,
    parameter int ROOT_BITS  = 8,
    parameter int LEVEL_BITS = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  op_beat_t            op_beat,
    output fire_beat_t          fire_beat,
    output logic                fire_valid,
    input  logic                fire_stall,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    input  htw_cmd_t            cmd,
    output htw_status_t         status
);

    localparam int ROOT_SIZE  = 1 << ROOT_BITS;
    localparam int LEVEL_SIZE = 1 << LEVEL_BITS;
    localparam int SLOT_W     = $clog2(ROOT_SIZE + NUM_LEVELS * LEVEL_SIZE);
    localparam int IDX_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int ENTRY_W    = TIME_W + SLOT_W;
    localparam int TOP_SHIFT  = ROOT_BITS + (NUM_LEVELS - 1) * LEVEL_BITS;

    logic [TIME_W-1:0]     start_time_reg;
    logic [TIME_W-1:0]     cur_time_reg;
    logic [TIME_W-1:0]     tick_time_reg;
    logic [MAX_TIMERS-1:0] valid_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [LVL_W-1:0]      lvl_reg;
    logic [IDX_W-1:0]      op_id_reg;
    logic [TIME_W-1:0]     op_exp_reg;
    logic [IDX_W-1:0]      place_id_reg;
    logic [TIME_W-1:0]     place_exp_reg;
    logic [TIME_W-1:0]     dist_reg;
    logic                  held_valid_reg;
    logic [IDX_W-1:0]      held_id_reg;
    logic                  fire_valid_reg;
    fire_beat_t            fire_beat_reg;

    logic                  cfg_wr;
    logic                  in_id_ok;
    logic [IDX_W-1:0]      in_idx;
    logic [ENTRY_W-1:0]    rd_entry;
    logic [TIME_W-1:0]     rd_exp;
    logic [SLOT_W-1:0]     rd_slot;
    logic [TIME_W-1:0]     place_exp_sel;
    logic [IDX_W-1:0]      place_id_sel;
    logic [LEVEL_BITS-1:0] lvl_index [NUM_LEVELS];
    logic [LEVEL_BITS-1:0] lvl_index_sel;
    logic [SLOT_W-1:0]     cas_target;
    logic [SLOT_W-1:0]     root_target;
    logic                  fits_root;
    logic [NUM_LEVELS-2:0] fits_lvl;
    logic [TIME_W-1:0]     dist_clamped;
    logic [TIME_W-1:0]     top_sum;
    logic [SLOT_W-1:0]     slot_calc;
    logic                  out_free;
    logic                  out_load;

    assign cfg_wr   = psel && penable && pwrite && pready && (paddr[3] == REG_START_TIME);
    assign pready   = 1'b1;
    assign prdata   = (paddr[3] == REG_START_TIME) ? start_time_reg : '0;
    assign in_id_ok = 32'(op_beat.timer_id) < MAX_TIMERS;
    assign in_idx   = IDX_W'(op_beat.timer_id);

    htw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TIMERS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (cmd.place_write),
        .waddr (place_id_reg),
        .wdata ({place_exp_reg, slot_calc}),
        .raddr (idx_reg),
        .rdata (rd_entry)
    );

    assign rd_exp  = rd_entry[SLOT_W +: TIME_W];
    assign rd_slot = rd_entry[SLOT_W-1:0];

    always_comb
    begin
        for (int n = 0; n < NUM_LEVELS; n++)
        begin
            lvl_index[n] = tick_time_reg[ROOT_BITS + n * LEVEL_BITS +: LEVEL_BITS];
        end
        lvl_index_sel = lvl_index[lvl_reg];
        cas_target    = SLOT_W'(ROOT_SIZE) + (SLOT_W'(lvl_reg) << LEVEL_BITS)
                      + SLOT_W'(lvl_index_sel);
        root_target   = SLOT_W'(tick_time_reg[ROOT_BITS-1:0]);
    end

    assign place_exp_sel = cmd.place_from_ram ? rd_exp : op_exp_reg;
    assign place_id_sel  = cmd.place_from_ram ? idx_reg : op_id_reg;

    always_comb
    begin
        fits_root = (dist_reg >> ROOT_BITS) == '0;
        for (int n = 0; n < NUM_LEVELS - 1; n++)
        begin
            fits_lvl[n] = (dist_reg >> (ROOT_BITS + (n + 1) * LEVEL_BITS)) == '0;
        end
        dist_clamped = (dist_reg[TIME_W-1:32] != '0) ? TOP_CLAMP : dist_reg;
        top_sum      = cur_time_reg + dist_clamped;
        slot_calc    = SLOT_W'(ROOT_SIZE + (NUM_LEVELS - 1) * LEVEL_SIZE)
                     + SLOT_W'(top_sum[TOP_SHIFT +: LEVEL_BITS]);
        if (dist_reg[TIME_W-1])
        begin
            slot_calc = SLOT_W'(cur_time_reg[ROOT_BITS-1:0]);
        end
        for (int n = NUM_LEVELS - 2; n >= 0; n--)
        begin
            if (fits_lvl[n])
            begin
                slot_calc = SLOT_W'(ROOT_SIZE + n * LEVEL_SIZE)
                          + SLOT_W'(place_exp_reg[ROOT_BITS + n * LEVEL_BITS +: LEVEL_BITS]);
            end
        end
        if (fits_root)
        begin
            slot_calc = SLOT_W'(place_exp_reg[ROOT_BITS-1:0]);
        end
    end

    assign out_free = !fire_valid_reg || !fire_stall;
    assign out_load = (cmd.fire && held_valid_reg) || cmd.flush;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg <= '0;
            cur_time_reg   <= '0;
            valid_reg      <= '0;
            idx_reg        <= '0;
            lvl_reg        <= '0;
            held_valid_reg <= 1'b0;
            fire_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                start_time_reg <= pwdata;
                cur_time_reg   <= pwdata;
            end
            else if (cmd.advance)
            begin
                cur_time_reg <= cur_time_reg + 1'b1;
            end

            if (cmd.accept && op_beat.operation == OP_REMOVE && in_id_ok)
            begin
                valid_reg[in_idx] <= 1'b0;
            end
            if (cmd.place_write)
            begin
                valid_reg[place_id_reg] <= 1'b1;
            end
            if (cmd.fire)
            begin
                valid_reg[idx_reg] <= 1'b0;
            end

            if (cmd.start_tick || cmd.walk_first)
            begin
                idx_reg <= '0;
            end
            else if (cmd.walk_next)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            if (cmd.start_tick)
            begin
                lvl_reg <= '0;
            end
            else if (cmd.level_next)
            begin
                lvl_reg <= lvl_reg + 1'b1;
            end

            if (cmd.fire)
            begin
                held_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                held_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                fire_valid_reg <= 1'b1;
            end
            else if (!fire_stall)
            begin
                fire_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_id_reg  <= in_idx;
            op_exp_reg <= op_beat.expiry;
        end
        if (cmd.start_tick)
        begin
            tick_time_reg <= cur_time_reg;
        end
        if (cmd.place_calc)
        begin
            place_id_reg  <= place_id_sel;
            place_exp_reg <= place_exp_sel;
            dist_reg      <= place_exp_sel - cur_time_reg;
        end
        if (cmd.fire)
        begin
            held_id_reg <= idx_reg;
        end
        if (out_load)
        begin
            fire_beat_reg.fired_timer <= ID_W'(held_id_reg);
            fire_beat_reg.fire_time   <= tick_time_reg;
            fire_beat_reg.last        <= cmd.flush;
        end
    end

    assign fire_valid = fire_valid_reg;
    assign fire_beat  = fire_beat_reg;

    assign status.in_op       = op_beat.operation;
    assign status.in_id_ok    = in_id_ok;
    assign status.root_zero   = cur_time_reg[ROOT_BITS-1:0] == '0;
    assign status.level_zero  = lvl_index_sel == '0;
    assign status.last_level  = lvl_reg == LVL_W'(NUM_LEVELS - 1);
    assign status.walk_last   = idx_reg == IDX_W'(MAX_TIMERS - 1);
    assign status.entry_valid = valid_reg[idx_reg];
    assign status.cascade_hit = valid_reg[idx_reg] && (rd_slot == cas_target);
    assign status.fire_hit    = valid_reg[idx_reg] && (rd_slot == root_target);
    assign status.held_valid  = held_valid_reg;
    assign status.out_free    = out_free;

endmodule

// ----- src/htw_checker.sv -----
// Port-level checks of the timer wheel and their binding
`include "hierarchical_timer_wheel_defines.svh"

module htw_checker
    import htw_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       op_valid,
    input logic       op_stall,
    input op_beat_t   op_beat,
    input logic       fire_valid,
    input logic       fire_stall,
    input fire_beat_t fire_beat
);

    `HTW_ASSERT_NEXT(a_fire_hold, fire_valid && fire_stall, fire_valid && $stable(fire_beat))
    `HTW_ASSERT_NEXT(a_tick_busy, op_valid && !op_stall && op_beat.operation == OP_TICK, op_stall)
    `HTW_ASSERT_IMP(a_fire_in_tick, $rose(fire_valid), $past(op_stall))
    `HTW_ASSERT_IMP(a_add_done, op_valid && !op_stall && op_beat.operation == OP_ADD, ##3 !op_stall)

endmodule

bind hierarchical_timer_wheel htw_checker u_htw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_valid   (op_valid),
    .op_stall   (op_stall),
    .op_beat    (op_beat),
    .fire_valid (fire_valid),
    .fire_stall (fire_stall),
    .fire_beat  (fire_beat)
);
